// ===== rtl/slcan_pkg.sv =====
package slcan_pkg;

   localparam int MAX_DATA_BYTES_DEFAULT = 8;
   localparam int QUEUE_DEPTH            = 2;

   localparam logic [7:0] CH_EXT  = 8'h54;
   localparam logic [7:0] CH_STD  = 8'h74;
   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_ZERO = 8'h30;

   localparam logic [3:0] EXT_ID_DIGITS = 4'd8;
   localparam logic [3:0] STD_ID_DIGITS = 4'd3;
   localparam logic [4:0] INDEX_LIMIT   = 5'd26;

   localparam int ID_W      = 32;
   localparam int LEN_W     = 4;
   localparam int PAYLOAD_W = 64;
   localparam int NIBBLES   = PAYLOAD_W / 4;
   localparam int RSP_W     = 104;

   // one classified character
   typedef struct packed {
      logic       is_cr;
      logic       is_ext;
      logic       is_std;
      logic       is_hex;
      logic [3:0] nibble;
      logic       len_ok;
      logic [3:0] len_val;
   } token_type;

   // one decoded frame
   typedef struct packed {
      logic [PAYLOAD_W-1:0] payload;
      logic [LEN_W-1:0]     data_length;
      logic [ID_W-1:0]      can_id;
   } frame_type;

endpackage

// ===== rtl/slcan_frame_deframer.sv =====
// a carriage return item is held in the token queue, and its frame is then registered for rsp
// throughput: one item per cycle unless stalled, set by the single-step back-end line decoder
// while a result waits, the two-entry token queue fills with further items and then holds
// req_tready low; ready returns in the cycle after the waiting result is taken
// reset: synchronous, active high; clears the queue, the line state and the result valid
module slcan_frame_deframer #(
   parameter int MAX_DATA_BYTES = slcan_pkg::MAX_DATA_BYTES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   // received characters
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,    // [7:0] rx_byte
   // decoded frames
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [31:0] can_id, [35:32] data_length, [99:36] payload
   output logic [slcan_pkg::RSP_W-1:0] rsp_tdata
);

   // front end: classify each character into a token
   logic                 q_push;
   logic                 q_pop;
   logic                 q_full;
   logic                 q_not_empty;
   slcan_pkg::token_type push_token;
   slcan_pkg::token_type head_token;
   slcan_pkg::frame_type frame;

   slcan_front #(
      .MAX_DATA_BYTES(MAX_DATA_BYTES)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_token    (push_token)
   );

   // short queue decouples input from a stalled result
   slcan_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_token (push_token),
      .pop        (q_pop),
      .full       (q_full),
      .not_empty  (q_not_empty),
      .head       (head_token)
   );

   // back end: walk the line and build the frame, result held in an output register
   slcan_back #(
      .MAX_DATA_BYTES(MAX_DATA_BYTES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (head_token),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_frame   (frame)
   );

   // pad to whole bytes
   assign rsp_tdata = {4'b0000, frame};

endmodule

// ===== rtl/slcan_front.sv =====
module slcan_front #(
   parameter int MAX_DATA_BYTES = slcan_pkg::MAX_DATA_BYTES_DEFAULT
) (
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic                  q_full,
   output logic                  q_push,
   output slcan_pkg::token_type  q_token
);

   logic [7:0] len_diff;

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;
   assign len_diff   = req_tdata - slcan_pkg::CH_ZERO;

   always_comb begin
      q_token         = '0;
      q_token.is_cr   = (req_tdata == slcan_pkg::CH_CR);
      q_token.is_ext  = (req_tdata == slcan_pkg::CH_EXT);
      q_token.is_std  = (req_tdata == slcan_pkg::CH_STD);
      q_token.len_ok  = (len_diff <= 8'(MAX_DATA_BYTES));
      q_token.len_val = len_diff[3:0];
      if (req_tdata >= 8'h30 && req_tdata <= 8'h39) begin
         q_token.is_hex = 1'b1;
         q_token.nibble = len_diff[3:0];
      end else if (req_tdata >= 8'h41 && req_tdata <= 8'h46) begin
         q_token.is_hex = 1'b1;
         q_token.nibble = 4'(req_tdata - 8'h37);
      end else if (req_tdata >= 8'h61 && req_tdata <= 8'h66) begin
         q_token.is_hex = 1'b1;
         q_token.nibble = 4'(req_tdata - 8'h57);
      end
   end

endmodule

// ===== rtl/slcan_queue.sv =====
module slcan_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  slcan_pkg::token_type push_token,
   input  logic                 pop,
   output logic                 full,
   output logic                 not_empty,
   output slcan_pkg::token_type head
);

   localparam int DEPTH = slcan_pkg::QUEUE_DEPTH;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   slcan_pkg::token_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_token;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) full |-> !push)
      else $error("push into full queue");
   assert property (@(posedge clock) disable iff (reset) !not_empty |-> !pop)
      else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset) count_ff <= CW'(DEPTH))
      else $error("queue count overflow");

endmodule

// ===== rtl/slcan_back.sv =====
module slcan_back #(
   parameter int MAX_DATA_BYTES = slcan_pkg::MAX_DATA_BYTES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_not_empty,
   input  slcan_pkg::token_type q_head,
   output logic                 q_pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output slcan_pkg::frame_type rsp_frame
);

   localparam int NIB = slcan_pkg::NIBBLES;

   logic [4:0]  char_index_ff, char_index_in;
   logic        is_ext_ff, is_ext_in;
   logic [31:0] id_ff, id_in;
   logic [3:0]  len_ff, len_in;
   logic [63:0] data_ff, data_in;
   logic        bad_ff, bad_in;
   logic        rsp_valid_ff, rsp_valid_in;
   slcan_pkg::frame_type rsp_frame_ff, rsp_frame_in;

   logic       out_free;
   logic [5:0] pos;
   logic [5:0] id_len;
   logic [5:0] id_end;
   logic [5:0] data_end;
   logic [5:0] k;
   logic [3:0] byte_no;
   logic [3:0] nib_sel;
   logic       emit;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign q_pop      = q_not_empty && out_free;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_frame  = rsp_frame_ff;

   assign pos      = {1'b0, char_index_ff};
   assign id_len   = {2'b00, is_ext_ff ? slcan_pkg::EXT_ID_DIGITS : slcan_pkg::STD_ID_DIGITS};
   assign id_end   = id_len + 6'd2;
   assign data_end = id_end + {1'b0, len_ff, 1'b0};
   assign k        = pos - id_end;
   assign byte_no  = k[4:1];
   // high nibble of a byte comes first on the line
   assign nib_sel  = {byte_no[2:0], ~k[0]};
   assign emit     = (pos != '0) && !bad_ff && (pos >= id_end) && (pos >= data_end);

   always_comb begin
      char_index_in = char_index_ff;
      is_ext_in     = is_ext_ff;
      id_in         = id_ff;
      len_in        = len_ff;
      data_in       = data_ff;
      bad_in        = bad_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_frame_in  = rsp_frame_ff;
      if (q_pop) begin
         if (q_head.is_cr) begin
            if (emit) begin
               rsp_valid_in             = 1'b1;
               rsp_frame_in.can_id      = id_ff;
               rsp_frame_in.data_length = len_ff;
               rsp_frame_in.payload     = data_ff;
            end
            char_index_in = '0;
            is_ext_in     = 1'b0;
            id_in         = '0;
            len_in        = '0;
            data_in       = '0;
            bad_in        = 1'b0;
         end else begin
            if (pos == '0) begin
               is_ext_in = q_head.is_ext;
               if (!q_head.is_ext && !q_head.is_std) begin
                  bad_in = 1'b1;
               end
            end else if (pos <= id_len) begin
               if (!q_head.is_hex) begin
                  bad_in = 1'b1;
               end else begin
                  id_in = {id_ff[27:0], q_head.nibble};
               end
            end else if (pos == id_len + 6'd1) begin
               if (!q_head.len_ok) begin
                  bad_in = 1'b1;
               end else begin
                  len_in = q_head.len_val;
               end
            end else if (byte_no < len_ff) begin
               if (!q_head.is_hex) begin
                  bad_in = 1'b1;
               end else begin
                  for (int j = 0; j < NIB; j++) begin
                     if (nib_sel == 4'(j)) begin
                        data_in[j*4 +: 4] = data_ff[j*4 +: 4] | q_head.nibble;
                     end
                  end
               end
            end
            if (char_index_ff < slcan_pkg::INDEX_LIMIT) begin
               char_index_in = char_index_ff + 5'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_frame_ff <= rsp_frame_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_index_ff <= '0;
         is_ext_ff     <= 1'b0;
         id_ff         <= '0;
         len_ff        <= '0;
         data_ff       <= '0;
         bad_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         char_index_ff <= char_index_in;
         is_ext_ff     <= is_ext_in;
         id_ff         <= id_in;
         len_ff        <= len_in;
         data_ff       <= data_in;
         bad_ff        <= bad_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
                    char_index_ff <= slcan_pkg::INDEX_LIMIT)
      else $error("char index past limit");
   assert property (@(posedge clock) disable iff (reset)
                    (q_pop && q_head.is_cr) |=> (char_index_ff == '0 && !bad_ff))
      else $error("line state not cleared at end of line");
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid_ff |-> (rsp_frame_ff.data_length <= 4'(MAX_DATA_BYTES)))
      else $error("frame length out of range");
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid_ff && !rsp_tready) |-> !q_pop)
      else $error("token consumed while result stalled");

endmodule
